// ===== sv/rdni_pkg.sv =====
`timescale 1ns / 1ps

package rdni_pkg;

  // Fraction bits of the Q3.28 radius and of the Q1.62 coefficients.
  localparam int unsigned Frac = 28;
  localparam int unsigned CoefFrac = 62;
  // Bit position at which the Newton step size saturates.
  localparam int unsigned QuoBits = 40;

  localparam int unsigned MaxDistDef = 1024;

  localparam logic signed [63:0] K1Rst = 64'sd3172166000000000;
  localparam logic signed [63:0] K2Rst = -64'sd26522600000000;
  localparam logic signed [63:0] K3Rst = 64'sd199459000000;
  localparam logic signed [63:0] K4Rst = -64'sd86238529;
  localparam logic [31:0] InvRst = 32'd7158279;
  localparam logic [27:0] TolRst = 28'd27;
  localparam logic [6:0] LimRst = 7'd32;
  localparam logic [6:0] LimMax = 7'd64;

  localparam logic signed [63:0] OneQ = 64'sd1 <<< Frac;
  localparam logic signed [31:0] TwoQ = 32'sd2 <<< Frac;
  localparam logic signed [31:0] MinusOneQ = -(32'sd1 <<< Frac);

  // Which product bits the multiplier returns.
  typedef enum logic [1:0] {
    SH_Y = 2'd0,
    SH_P = 2'd1,
    SH_C = 2'd2
  } shift_sel_e;

  typedef enum logic [2:0] {
    REG_K1  = 3'd0,
    REG_K2  = 3'd1,
    REG_K3  = 3'd2,
    REG_K4  = 3'd3,
    REG_INV = 3'd4,
    REG_TOL = 3'd5,
    REG_LIM = 3'd6
  } reg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQRT  = 8'b0000_0010,
    ST_YMUL  = 8'b0000_0100,
    ST_PMUL  = 8'b0000_1000,
    ST_TMUL  = 8'b0001_0000,
    ST_CHECK = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] r;
    r = v[63] ? 64'(-v) : 64'(v);
    return r;
  endfunction

endpackage

// ===== sv/radial_distortion_newton_inverse_unit.sv =====
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// in       in_valid_i / in_stall_o    squared_distance_i
// out      out_valid_o / out_stall_i  corrected_radius_o, out_of_range_o,
//                                     not_converged_o, iterations_used_o
// cfg      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item is worked on at a time. A nonzero distance passes through the square
// root, the radius scaling and the first polynomial and check, then through each
// Newton step, paced by the bit-serial multiplier (16 products per polynomial)
// and the divider. A zero distance goes straight to the result. The result sits
// in an output register, so the next beat is taken while it waits. Reset restores
// the register defaults and a zero guess.
module radial_distortion_newton_inverse_unit import rdni_pkg::*; #(
  parameter int unsigned MaxDist = MaxDistDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [20:0]        squared_distance_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] corrected_radius_o,
  output logic               out_of_range_o,
  output logic               not_converged_o,
  output logic [6:0]         iterations_used_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam logic [24:0] DistCap = 25'(MaxDist * MaxDist);

  // Configuration registers.
  logic signed [63:0] k_q [4];
  logic [31:0] inv_q;
  logic [27:0] tol_q;
  logic [6:0]  lim_q;
  reg_idx_e    widx;
  logic        wr_en;

  state_e state_q;
  logic   go_q;
  logic [20:0] dist_q;
  logic [31:0] s_q;
  logic signed [31:0] x_q;
  logic signed [31:0] prev_q;
  logic signed [63:0] y_q;
  logic signed [63:0] f_q;
  logic signed [63:0] d_q;
  logic signed [63:0] p_q;
  logic [3:0]  n_q;
  logic [6:0]  steps_q;
  logic        oor_q;
  logic        nc_q;

  logic               out_valid_q;
  logic signed [31:0] out_rad_q;
  logic               out_oor_q;
  logic               out_nc_q;
  logic [6:0]         out_it_q;

  // Shared units.
  logic        sqrt_start, sqrt_done;
  logic [31:0] root;
  logic        mul_start, mul_done, mul_neg;
  logic [63:0] mul_a, mul_b;
  shift_sel_e  mul_sh;
  logic signed [63:0] prod;
  logic        div_start, div_done;
  logic [40:0] quo;

  logic signed [63:0] kc;
  logic signed [63:0] resid;
  logic [63:0] resid_mag;
  logic [6:0]  lim_eff;
  logic        step_neg;
  logic signed [63:0] dl;
  logic signed [63:0] x_new;
  logic signed [31:0] x_sat;
  logic signed [63:0] d_term;
  logic        in_accept;
  logic        out_load;

  assign pready = 1'b1;
  assign widx = reg_idx_e'(paddr[5:3]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q[0] <= K1Rst;
      k_q[1] <= K2Rst;
      k_q[2] <= K3Rst;
      k_q[3] <= K4Rst;
      inv_q  <= InvRst;
      tol_q  <= TolRst;
      lim_q  <= LimRst;
    end else if (wr_en) begin
      case (widx)
        REG_K1:  k_q[0] <= $signed(pwdata);
        REG_K2:  k_q[1] <= $signed(pwdata);
        REG_K3:  k_q[2] <= $signed(pwdata);
        REG_K4:  k_q[3] <= $signed(pwdata);
        REG_INV: inv_q  <= pwdata[31:0];
        REG_TOL: tol_q  <= pwdata[27:0];
        REG_LIM: lim_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_K1:  prdata = k_q[0];
      REG_K2:  prdata = k_q[1];
      REG_K3:  prdata = k_q[2];
      REG_K4:  prdata = k_q[3];
      REG_INV: prdata = {32'd0, inv_q};
      REG_TOL: prdata = {36'd0, tol_q};
      REG_LIM: prdata = {57'd0, lim_q};
      default: prdata = '0;
    endcase
  end

  // Datapath helpers. The coefficient for power n is k[(n-2)/2].
  assign kc = k_q[n_q[2:1] - 2'd1];
  assign resid = y_q - f_q;
  assign resid_mag = mag64(resid);
  assign lim_eff = (lim_q > LimMax) ? LimMax : lim_q;
  // The step is subtracted, so its sign follows (f - y) against f'.
  assign step_neg = (resid > 0) != d_q[63];
  assign dl = step_neg ? -$signed({23'd0, quo}) : $signed({23'd0, quo});
  assign x_new = 64'(x_q) - dl;

  always_comb begin
    if (x_new > 64'sd2147483647) begin
      x_sat = 32'sh7fffffff;
    end else if (x_new < -64'sd2147483648) begin
      x_sat = 32'sh80000000;
    end else begin
      x_sat = x_new[31:0];
    end
  end

  // Derivative terms carry the power's exponent plus one as a weight.
  always_comb begin
    case (n_q)
      4'd2:    d_term = prod + (prod <<< 1);
      4'd4:    d_term = prod + (prod <<< 2);
      4'd6:    d_term = (prod <<< 3) - prod;
      4'd8:    d_term = (prod <<< 3) + prod;
      default: d_term = '0;
    endcase
  end

  assign sqrt_start = go_q && (state_q == ST_SQRT);
  assign div_start  = go_q && (state_q == ST_DIV);
  assign mul_start  = go_q && (state_q == ST_YMUL || state_q == ST_PMUL ||
                               state_q == ST_TMUL);

  always_comb begin
    mul_a   = mag64(p_q);
    mul_b   = mag64(64'(x_q));
    mul_neg = p_q[63] ^ x_q[31];
    mul_sh  = SH_P;
    case (state_q)
      ST_YMUL: begin
        mul_a   = {32'd0, s_q};
        mul_b   = {32'd0, inv_q};
        mul_neg = 1'b0;
        mul_sh  = SH_Y;
      end
      ST_TMUL: begin
        mul_a   = mag64(kc);
        mul_b   = mag64(p_q);
        mul_neg = kc[63] ^ p_q[63];
        mul_sh  = SH_C;
      end
      default: ;
    endcase
  end

  rdni_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ({1'b0, dist_q, 42'd0}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  rdni_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .neg_i   (mul_neg),
    .sh_i    (mul_sh),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  rdni_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (resid_mag),
    .den_i   (mag64(d_q)),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      prev_q  <= '0;
    end else begin
      go_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (squared_distance_i == 21'd0) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SQRT;
              go_q    <= 1'b1;
            end
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            state_q <= ST_YMUL;
            go_q    <= 1'b1;
          end
        end
        ST_YMUL: begin
          if (mul_done) begin
            state_q <= ST_PMUL;
            go_q    <= 1'b1;
          end
        end
        ST_PMUL: begin
          if (mul_done) begin
            state_q <= ST_TMUL;
            go_q    <= 1'b1;
          end
        end
        ST_TMUL: begin
          if (mul_done) begin
            if (n_q == 4'd9) begin
              state_q <= ST_CHECK;
            end else begin
              state_q <= ST_PMUL;
              go_q    <= 1'b1;
            end
          end
        end
        ST_CHECK: begin
          if (resid_mag <= {36'd0, tol_q} || steps_q >= lim_eff || d_q == 64'sd0) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_DIV;
            go_q    <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (x_sat > TwoQ) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_PMUL;
              go_q    <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            prev_q  <= x_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        steps_q <= '0;
        oor_q   <= 1'b0;
        nc_q    <= 1'b0;
        if ({4'd0, squared_distance_i} > DistCap) begin
          dist_q <= DistCap[20:0];
        end else begin
          dist_q <= squared_distance_i;
        end
        x_q <= (squared_distance_i == 21'd0) ? 32'sd0 : prev_q;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          s_q <= root;
        end
      end
      ST_YMUL: begin
        if (mul_done) begin
          y_q <= prod;
          p_q <= 64'(x_q);
          f_q <= 64'(x_q);
          d_q <= OneQ;
          n_q <= 4'd2;
        end
      end
      ST_PMUL: begin
        if (mul_done) begin
          p_q <= prod;
        end
      end
      ST_TMUL: begin
        if (mul_done) begin
          if (n_q[0]) begin
            f_q <= f_q + prod;
          end else begin
            d_q <= d_q + d_term;
          end
          n_q <= n_q + 4'd1;
        end
      end
      ST_CHECK: begin
        if (resid_mag > {36'd0, tol_q} && (steps_q >= lim_eff || d_q == 64'sd0)) begin
          nc_q <= 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          steps_q <= steps_q + 7'd1;
          if (x_sat > TwoQ) begin
            oor_q <= 1'b1;
            x_q   <= MinusOneQ;
          end else begin
            x_q <= x_sat;
            p_q <= 64'(x_sat);
            f_q <= 64'(x_sat);
            d_q <= OneQ;
            n_q <= 4'd2;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rad_q <= x_q;
      out_oor_q <= oor_q;
      out_nc_q  <= nc_q;
      out_it_q  <= steps_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign corrected_radius_o = out_rad_q;
  assign out_of_range_o     = out_oor_q;
  assign not_converged_o    = out_nc_q;
  assign iterations_used_o  = out_it_q;

endmodule

// ===== sv/rdni_mul.sv =====
`timescale 1ns / 1ps

// Shift-and-add multiplier on magnitudes, one multiplier bit per cycle.
module rdni_mul import rdni_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  input  logic               neg_i,
  input  shift_sel_e         sh_i,
  output logic               done_o,
  output logic signed [63:0] prod_o
);

  logic [63:0]  a_q;
  logic [127:0] acc_q;
  logic         neg_q;
  shift_sel_e   sh_q;
  logic [5:0]   cnt_q;
  logic         busy_q;
  logic         done_q;
  logic [64:0]  sum;
  logic [63:0]  m;

  assign sum = {1'b0, acc_q[127:64]} + (acc_q[0] ? {1'b0, a_q} : 65'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {64'd0, b_i};
      neg_q <= neg_i;
      sh_q  <= sh_i;
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[63:1]};
    end
  end

  always_comb begin
    case (sh_q)
      SH_Y:    m = acc_q[88:25];
      SH_P:    m = acc_q[Frac+63:Frac];
      SH_C:    m = acc_q[CoefFrac+63:CoefFrac];
      default: m = '0;
    endcase
  end

  assign prod_o = neg_q ? -$signed(m) : $signed(m);
  assign done_o = done_q;

endmodule

// ===== sv/rdni_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Returns
// num * 2^28 / den, saturated to 2^40.
module rdni_div import rdni_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [40:0] quo_o
);

  localparam int unsigned DivSteps = 64 + Frac;
  localparam int unsigned SatLast = DivSteps - QuoBits - 1;

  logic [63:0] dvd_q;
  logic [63:0] den_q;
  logic [63:0] rem_q;
  logic [QuoBits-1:0] q_q;
  logic        sat_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [63:0] shifted;
  logic        ge;

  assign shifted = {rem_q[62:0], dvd_q[63]};
  assign ge = shifted >= den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= ge ? shifted - den_q : shifted;
      q_q   <= {q_q[QuoBits-2:0], ge};
      if (ge && cnt_q <= 7'(SatLast)) begin
        sat_q <= 1'b1;
      end
    end
  end

  assign quo_o  = sat_q ? (41'd1 << QuoBits) : {1'b0, q_q};
  assign done_o = done_q;

endmodule

// ===== sv/rdni_sqrt.sv =====
`timescale 1ns / 1ps

// Bit-pair integer square root, two radicand bits per cycle.
module rdni_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] v_q;
  logic [63:0] r_q;
  logic [63:0] bit_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [63:0] trial;
  logic        ge;

  assign trial = r_q + bit_q;
  assign ge = v_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= rad_i;
      r_q   <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (ge) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = r_q[31:0];
  assign done_o = done_q;

endmodule
